// ===== sv/coincidence_time_window_grouper_top_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the coincidence grouper
// Clocked, reset-gated concurrent and next-cycle property checks.
// ----------------------------------------------------------------------------
`ifndef COINCIDENCE_TIME_WINDOW_GROUPER_TOP_ASSERT_SVH
`define COINCIDENCE_TIME_WINDOW_GROUPER_TOP_ASSERT_SVH

// Check a property at every clock edge outside reset.
`define CWG_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define CWG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/cwg_pkg.sv =====
// ----------------------------------------------------------------------------
// Coincidence grouper package
// Shared sizes, codes and record types of the event builder.
// ----------------------------------------------------------------------------
`default_nettype none

package cwg_pkg;

  localparam int MAX_EVENT_HITS = 16;
  localparam int IDX_W          = $clog2(MAX_EVENT_HITS);

  localparam logic [1:0] FLAG_GOOD    = 2'd0;
  localparam logic [1:0] FLAG_CORRUPT = 2'd1;
  localparam logic [1:0] FLAG_MC      = 2'd2;
  localparam logic [1:0] FLAG_UNKNOWN = 2'd3;

  localparam logic [1:0] RECO_GOOD    = 2'd0;
  localparam logic [1:0] RECO_CORRUPT = 2'd1;

  localparam logic [1:0] CFG_WINDOW        = 2'd0;
  localparam logic [1:0] CFG_MIN_HITS      = 2'd1;
  localparam logic [1:0] CFG_USE_CORRUPTED = 2'd2;

  typedef struct packed {
    logic [47:0] hit_time;
    logic [15:0] tag;
    logic [1:0]  reco;
    logic        mc;
  } entry_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    entry_t           wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    entry_t      entry;
    logic [1:0]  event_flag;
    logic [7:0]  event_size;
    logic        truncated;
    logic        last;
  } result_t;

endpackage

`default_nettype wire

// ===== sv/coincidence_time_window_grouper_top.sv =====
// ----------------------------------------------------------------------------
// Coincidence time window grouper
// Groups time-ordered hits into events and streams out qualifying events.
// ----------------------------------------------------------------------------
// Sequence: a joining hit is registered, then written in the check state; an opening
//   hit goes through check and open; end of window adds flush and any readout.
// Readout: each emitted hit is a buffer read, then an output load that waits on a
//   stalled output; the one-item-at-a-time sequencer takes no item while busy.
// Reset: clears event state, readout sequencer and registers to defaults;
//   the hit buffer is not cleared and needs no pass.
`default_nettype none

module coincidence_time_window_grouper_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [63:0] s_axis_tdata,  // hit_time[47:0], hit_tag[63:48]
  input  wire logic [2:0]  s_axis_tuser,  // reco_flag[1:0], is_monte_carlo[2]
  input  wire logic        s_axis_tlast,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [71:0]      m_axis_tdata,  // out_time[47:0], out_tag[63:48], event_size[71:64]
  output logic [5:0]       m_axis_tuser,  // out_reco_flag[1:0], out_is_monte_carlo[2],
                                          // event_flag[4:3], truncated[5]
  output logic             m_axis_tlast
);

  cwg_pkg::mem_req_t mem_req;
  cwg_pkg::entry_t   mem_rdata;
  cwg_pkg::result_t  res;

  cwg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_time_i   (s_axis_tdata[47:0]),
    .in_tag_i    (s_axis_tdata[63:48]),
    .in_reco_i   (s_axis_tuser[1:0]),
    .in_mc_i     (s_axis_tuser[2]),
    .in_eow_i    (s_axis_tlast),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_o       (res)
  );

  cwg_hit_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  assign m_axis_tdata = {res.event_size, res.entry.tag, res.entry.hit_time};
  assign m_axis_tuser = {res.truncated, res.event_flag, res.entry.mc, res.entry.reco};
  assign m_axis_tlast = res.last;

endmodule

`default_nettype wire

// ===== sv/cwg_hit_ram.sv =====
// ----------------------------------------------------------------------------
// Hit buffer
// One-write, one-read synchronous memory of the open event's hits.
// ----------------------------------------------------------------------------
`default_nettype none

module cwg_hit_ram (
  input  wire logic              clk_i,
  input  wire cwg_pkg::mem_req_t req_i,
  output cwg_pkg::entry_t        rdata_o
);

  cwg_pkg::entry_t mem_q [cwg_pkg::MAX_EVENT_HITS];
  cwg_pkg::entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== sv/cwg_ctrl.sv =====
// ----------------------------------------------------------------------------
// Grouper control
// Window test, event state, buffer writes and readout sequencing.
// ----------------------------------------------------------------------------
`default_nettype none
`include "coincidence_time_window_grouper_top_assert.svh"

module cwg_ctrl (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [47:0]                   in_time_i,
  input  wire logic [15:0]                   in_tag_i,
  input  wire logic [1:0]                    in_reco_i,
  input  wire logic                          in_mc_i,
  input  wire logic                          in_eow_i,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [1:0]                    cfg_index_i,
  input  wire logic [31:0]                   cfg_data_i,
  output cwg_pkg::mem_req_t                  mem_req_o,
  input  wire cwg_pkg::entry_t               mem_rdata_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output cwg_pkg::result_t                   out_o
);

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_CHECK   = 3'd1;
  localparam logic [2:0] ST_OPEN    = 3'd2;
  localparam logic [2:0] ST_FLUSH   = 3'd3;
  localparam logic [2:0] ST_EMIT_RD = 3'd4;
  localparam logic [2:0] ST_EMIT_LD = 3'd5;

  localparam logic [7:0] MAX_CNT = 8'(cwg_pkg::MAX_EVENT_HITS);

  logic [2:0]  state_q, state_d;
  logic        open_q, open_d;
  logic [47:0] first_q, first_d;
  logic [7:0]  count_q, count_d;
  logic [1:0]  flag_q, flag_d;
  logic        after_open_q, after_open_d;
  logic [cwg_pkg::IDX_W-1:0] k_q, k_d;
  logic        out_valid_q, out_valid_d;
  logic        load_out;

  logic [31:0] window_q;
  logic [7:0]  min_hits_q;
  logic        use_corr_q;

  cwg_pkg::entry_t  hit_q;
  logic             eow_q;
  cwg_pkg::result_t out_q, out_d;

  logic        accept;
  logic [48:0] diff_fwd;
  logic [47:0] diff_abs;
  logic        in_win;
  logic        open_allowed;
  logic        store_ok;
  logic [7:0]  cnt_inc;
  logic [7:0]  cnt_m1;
  logic        emit_ok;
  logic        out_free;
  logic [1:0]  open_flag;
  logic [7:0]  stored_cnt_m1;

  assign accept      = in_valid_i && in_ready_o;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || out_ready_i;

  assign diff_fwd     = {1'b0, hit_q.hit_time} - {1'b0, first_q};
  assign diff_abs     = diff_fwd[48] ? (first_q - hit_q.hit_time) : diff_fwd[47:0];
  assign in_win       = diff_abs < {16'd0, window_q};
  assign open_allowed = !(hit_q.reco == cwg_pkg::RECO_CORRUPT && !use_corr_q);
  assign store_ok     = count_q < MAX_CNT;
  assign cnt_inc      = (count_q == 8'hFF) ? count_q : count_q + 8'd1;
  assign cnt_m1       = count_q - 8'd1;
  assign emit_ok      = open_q && (count_q >= min_hits_q);

  always_comb begin
    case (hit_q.reco)
      cwg_pkg::RECO_GOOD:    open_flag = cwg_pkg::FLAG_GOOD;
      cwg_pkg::RECO_CORRUPT: open_flag = cwg_pkg::FLAG_CORRUPT;
      default:               open_flag = cwg_pkg::FLAG_UNKNOWN;
    endcase
    if (hit_q.mc) begin
      open_flag = cwg_pkg::FLAG_MC;
    end
  end

  assign stored_cnt_m1 = (count_q >= MAX_CNT) ? (MAX_CNT - 8'd1) : cnt_m1;

  always_comb begin
    state_d      = state_q;
    open_d       = open_q;
    first_d      = first_q;
    count_d      = count_q;
    flag_d       = flag_q;
    after_open_d = after_open_q;
    k_d          = k_q;
    load_out     = 1'b0;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_d        = out_q;

    mem_req_o.we    = 1'b0;
    mem_req_o.waddr = count_q[cwg_pkg::IDX_W-1:0];
    mem_req_o.wdata = hit_q;
    mem_req_o.re    = 1'b0;
    mem_req_o.raddr = k_q;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (open_q && in_win) begin
          if (hit_q.reco == cwg_pkg::RECO_CORRUPT) begin
            flag_d = cwg_pkg::FLAG_CORRUPT;
          end
          mem_req_o.we = store_ok;
          count_d      = cnt_inc;
          state_d      = eow_q ? ST_FLUSH : ST_IDLE;
        end else if (emit_ok) begin
          after_open_d = 1'b1;
          k_d          = '0;
          state_d      = ST_EMIT_RD;
        end else begin
          open_d  = 1'b0;
          count_d = 8'd0;
          flag_d  = cwg_pkg::FLAG_UNKNOWN;
          first_d = 48'd0;
          state_d = ST_OPEN;
        end
      end
      ST_OPEN: begin
        if (open_allowed) begin
          open_d          = 1'b1;
          first_d         = hit_q.hit_time;
          flag_d          = open_flag;
          count_d         = 8'd1;
          mem_req_o.we    = 1'b1;
          mem_req_o.waddr = '0;
        end
        state_d = eow_q ? ST_FLUSH : ST_IDLE;
      end
      ST_FLUSH: begin
        if (emit_ok) begin
          after_open_d = 1'b0;
          k_d          = '0;
          state_d      = ST_EMIT_RD;
        end else begin
          open_d  = 1'b0;
          count_d = 8'd0;
          flag_d  = cwg_pkg::FLAG_UNKNOWN;
          first_d = 48'd0;
          state_d = ST_IDLE;
        end
      end
      ST_EMIT_RD: begin
        mem_req_o.re = 1'b1;
        state_d      = ST_EMIT_LD;
      end
      ST_EMIT_LD: begin
        if (out_free) begin
          load_out         = 1'b1;
          out_valid_d      = 1'b1;
          out_d.entry      = mem_rdata_i;
          out_d.event_flag = flag_q;
          out_d.event_size = count_q;
          out_d.truncated  = count_q > MAX_CNT;
          out_d.last       = ({{(8-cwg_pkg::IDX_W){1'b0}}, k_q} == stored_cnt_m1);
          if ({{(8-cwg_pkg::IDX_W){1'b0}}, k_q} == stored_cnt_m1) begin
            open_d  = 1'b0;
            count_d = 8'd0;
            flag_d  = cwg_pkg::FLAG_UNKNOWN;
            first_d = 48'd0;
            state_d = after_open_q ? ST_OPEN : ST_IDLE;
          end else begin
            k_d     = k_q + 1'b1;
            state_d = ST_EMIT_RD;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      open_q       <= 1'b0;
      first_q      <= 48'd0;
      count_q      <= 8'd0;
      flag_q       <= cwg_pkg::FLAG_UNKNOWN;
      after_open_q <= 1'b0;
      k_q          <= '0;
      out_valid_q  <= 1'b0;
      window_q     <= 32'd5000;
      min_hits_q   <= 8'd1;
      use_corr_q   <= 1'b0;
    end else begin
      state_q      <= state_d;
      open_q       <= open_d;
      first_q      <= first_d;
      count_q      <= count_d;
      flag_q       <= flag_d;
      after_open_q <= after_open_d;
      k_q          <= k_d;
      out_valid_q  <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          cwg_pkg::CFG_WINDOW:        window_q   <= cfg_data_i;
          cwg_pkg::CFG_MIN_HITS:      min_hits_q <= cfg_data_i[7:0];
          cwg_pkg::CFG_USE_CORRUPTED: use_corr_q <= cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      hit_q.hit_time <= in_time_i;
      hit_q.tag      <= in_tag_i;
      hit_q.reco     <= in_reco_i;
      hit_q.mc       <= in_mc_i;
      eow_q          <= in_eow_i;
    end
    if (load_out) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  `CWG_ASSERT(a_open_nonempty, clk_i, rst_ni, open_q |-> (count_q != 8'd0), "open event is empty")
  `CWG_ASSERT(a_load_in_emit, clk_i, rst_ni, $rose(out_valid_q) |-> ($past(state_q) == ST_EMIT_LD), "result loaded outside readout")
  `CWG_ASSERT(a_index_bound, clk_i, rst_ni, ((state_q == ST_EMIT_RD) || (state_q == ST_EMIT_LD)) |-> ({{(8-cwg_pkg::IDX_W){1'b0}}, k_q} <= stored_cnt_m1), "readout index past stored hits")
  `CWG_ASSERT_NEXT(a_close_after_last, clk_i, rst_ni, load_out && out_d.last, !open_q && (count_q == 8'd0), "event not closed after its last hit")

endmodule

`default_nettype wire
